/* hdl/lpca_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpca_pkg
// shared types, widths and constants of the lidar point cluster averager
// ----------------------------------------------------------------------------
package lpca_pkg;

    localparam int MAX_POINTS = 8192;
    localparam int COUNT_CAP  = (MAX_POINTS > 16383) ? 16383 : MAX_POINTS;

    localparam int ANGLE_W  = 16;
    localparam int DIST_W   = 16;
    localparam int CNT_W    = 14;
    localparam int MEAN_A_W = 16;
    localparam int MEAN_D_W = 18;
    localparam int CFG_IDX_W = 2;

    // widest cluster sum, sized by the count cap
    localparam int SUM_W  = $clog2(COUNT_CAP * ((1 << ANGLE_W) - 1) + 1);
    localparam int QUOT_W = ANGLE_W + 2;
    localparam int STEP_W = 5;

    localparam logic [ANGLE_W-1:0] ANGLE_GAP_RESET = 16'd911;
    localparam logic [DIST_W-1:0]  DIST_GAP_RESET  = 16'd40;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_GAP  = 2'd1;

    // quotient bits per division: angle mean, then four times distance mean
    localparam logic [STEP_W-1:0] STEPS_ANGLE = 5'd16;
    localparam logic [STEP_W-1:0] STEPS_DIST  = 5'd18;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_ANG,
        ST_DIV_DST,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [CNT_W-1:0]  divisor;
        logic [CNT_W-1:0]  rem_init;
        logic [QUOT_W-1:0] low_bits;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

endpackage

/* hdl/lidar_point_cluster_averager.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_point_cluster_averager
// breakpoint segmentation of a lidar scan into averaged point clusters
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one point per beat (angle, distance, scan_end), ascending angle
//   m_ channel: one cluster per beat (mean angle, 4x mean distance, count,
//     scan_done, last_of_run); an input point gives zero, one or two beats
//   cfg channel: writes the angle and distance gap limits, always ready;
//     write only while the block is idle, unknown indexes are ignored
//   a point that only extends or opens a cluster is taken at once, s_ready stays high
//   a cluster result comes from one shared restoring divider, which makes
//     16 quotient bits for the angle mean then 18 for the distance mean, one
//     bit per cycle; the empty end-of-scan marker needs no division
//   a point that closes a cluster and ends the scan gives two results
//   s_ready is low after the accepting beat until the last result is taken
//   m_ stall: the result sits in its output registers, the block waits
//   reset: synchronous, active low; limits go to 911 and 40, no cluster open
// ----------------------------------------------------------------------------
module lidar_point_cluster_averager (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // point input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lpca_pkg::ANGLE_W-1:0]         s_point_angle,
    input  logic [lpca_pkg::DIST_W-1:0]          s_point_dist,
    input  logic                                 s_scan_end,
    // cluster output
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [lpca_pkg::MEAN_A_W-1:0]        m_mean_angle,
    output logic [lpca_pkg::MEAN_D_W-1:0]        m_mean_dist_q2,
    output logic [lpca_pkg::CNT_W-1:0]           m_point_count,
    output logic                                 m_scan_done,
    output logic                                 m_last_of_run,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lpca_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [15:0]                          cfg_data
);

    lpca_pkg::state_t                state_reg, state_next;

    // gap limits
    logic [lpca_pkg::ANGLE_W-1:0]    angle_gap_reg;
    logic [lpca_pkg::DIST_W-1:0]     dist_gap_reg;

    // open cluster and history
    logic [lpca_pkg::ANGLE_W-1:0]    prev_angle_reg, prev_angle_next;
    logic [lpca_pkg::DIST_W-1:0]     prev_dist_reg, prev_dist_next;
    logic [lpca_pkg::SUM_W-1:0]      angle_sum_reg, angle_sum_next;
    logic [lpca_pkg::SUM_W-1:0]      dist_sum_reg, dist_sum_next;
    logic [lpca_pkg::CNT_W-1:0]      count_reg, count_next;

    // sequencer control
    logic                            pend_end_reg, pend_end_next;
    logic                            kick_reg, kick_next;

    // cluster being reported
    logic [lpca_pkg::SUM_W-1:0]      job_asum_reg, job_asum_next;
    logic [lpca_pkg::SUM_W-1:0]      job_dsum_reg, job_dsum_next;
    logic [lpca_pkg::CNT_W-1:0]      job_cnt_reg, job_cnt_next;
    logic                            job_done_reg, job_done_next;
    logic                            job_last_reg, job_last_next;
    logic [lpca_pkg::MEAN_A_W-1:0]   mean_a_reg, mean_a_next;
    logic [lpca_pkg::MEAN_D_W-1:0]   mean_d_reg, mean_d_next;

    // point evaluation
    logic [lpca_pkg::ANGLE_W-1:0]    a_jump;
    logic [lpca_pkg::DIST_W-1:0]     d_jump;
    logic                            kept;
    logic                            cont;
    logic                            split;
    logic [lpca_pkg::SUM_W-1:0]      pt_asum;
    logic [lpca_pkg::SUM_W-1:0]      pt_dsum;
    logic [lpca_pkg::CNT_W-1:0]      pt_cnt;
    logic [lpca_pkg::SUM_W-1:0]      div_sum;

    lpca_pkg::div_req_t              div_req;
    lpca_pkg::div_rsp_t              div_rsp;

    // ------------------------------------------------------------------
    // point classification against the previous kept point
    // ------------------------------------------------------------------
    assign kept   = s_point_dist != '0;
    assign a_jump = (s_point_angle > prev_angle_reg) ? s_point_angle - prev_angle_reg
                                                     : prev_angle_reg - s_point_angle;
    assign d_jump = (s_point_dist > prev_dist_reg) ? s_point_dist - prev_dist_reg
                                                   : prev_dist_reg - s_point_dist;
    // a full cluster closes instead of growing
    assign cont   = (count_reg != '0) && (a_jump < angle_gap_reg)
                 && (d_jump < dist_gap_reg)
                 && (count_reg < lpca_pkg::CNT_W'(lpca_pkg::COUNT_CAP));
    // a kept point that breaks an open cluster
    assign split  = kept && !cont && (count_reg != '0);

    // open cluster after this point
    always_comb begin
        pt_asum = angle_sum_reg;
        pt_dsum = dist_sum_reg;
        pt_cnt  = count_reg;
        if (kept) begin
            if (cont) begin
                pt_asum = angle_sum_reg + lpca_pkg::SUM_W'(s_point_angle);
                pt_dsum = dist_sum_reg + lpca_pkg::SUM_W'(s_point_dist);
                pt_cnt  = count_reg + 1'b1;
            end else begin
                pt_asum = lpca_pkg::SUM_W'(s_point_angle);
                pt_dsum = lpca_pkg::SUM_W'(s_point_dist);
                pt_cnt  = lpca_pkg::CNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lpca_pkg::ST_IDLE: begin
                if (s_valid && (split || s_scan_end)) begin
                    // empty end marker goes straight out
                    if (split || (pt_cnt != '0)) begin
                        state_next = lpca_pkg::ST_DIV_ANG;
                    end else begin
                        state_next = lpca_pkg::ST_SEND;
                    end
                end
            end
            lpca_pkg::ST_DIV_ANG: begin
                if (div_rsp.done) begin
                    state_next = lpca_pkg::ST_DIV_DST;
                end
            end
            lpca_pkg::ST_DIV_DST: begin
                if (div_rsp.done) begin
                    state_next = lpca_pkg::ST_SEND;
                end
            end
            lpca_pkg::ST_SEND: begin
                if (m_ready) begin
                    if (!pend_end_reg) begin
                        state_next = lpca_pkg::ST_IDLE;
                    end else if (count_reg != '0) begin
                        state_next = lpca_pkg::ST_DIV_ANG;
                    end else begin
                        state_next = lpca_pkg::ST_SEND;
                    end
                end
            end
            default: begin
                state_next = lpca_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // datapath updates
    // ------------------------------------------------------------------
    always_comb begin
        prev_angle_next = prev_angle_reg;
        prev_dist_next  = prev_dist_reg;
        angle_sum_next  = angle_sum_reg;
        dist_sum_next   = dist_sum_reg;
        count_next      = count_reg;
        pend_end_next   = pend_end_reg;
        kick_next       = 1'b0;
        job_asum_next   = job_asum_reg;
        job_dsum_next   = job_dsum_reg;
        job_cnt_next    = job_cnt_reg;
        job_done_next   = job_done_reg;
        job_last_next   = job_last_reg;
        mean_a_next     = mean_a_reg;
        mean_d_next     = mean_d_reg;
        case (state_reg)
            lpca_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (kept) begin
                        prev_angle_next = s_point_angle;
                        prev_dist_next  = s_point_dist;
                    end
                    if (split) begin
                        // report the broken cluster, keep the new one open
                        job_asum_next  = angle_sum_reg;
                        job_dsum_next  = dist_sum_reg;
                        job_cnt_next   = count_reg;
                        job_done_next  = 1'b0;
                        job_last_next  = !s_scan_end;
                        pend_end_next  = s_scan_end;
                        angle_sum_next = pt_asum;
                        dist_sum_next  = pt_dsum;
                        count_next     = pt_cnt;
                        kick_next      = 1'b1;
                    end else if (s_scan_end) begin
                        // flush and clear everything
                        job_asum_next   = pt_asum;
                        job_dsum_next   = pt_dsum;
                        job_cnt_next    = pt_cnt;
                        job_done_next   = 1'b1;
                        job_last_next   = 1'b1;
                        prev_angle_next = '0;
                        prev_dist_next  = '0;
                        angle_sum_next  = '0;
                        dist_sum_next   = '0;
                        count_next      = '0;
                        kick_next       = pt_cnt != '0;
                        if (pt_cnt == '0) begin
                            mean_a_next = '0;
                            mean_d_next = '0;
                        end
                    end else begin
                        angle_sum_next = pt_asum;
                        dist_sum_next  = pt_dsum;
                        count_next     = pt_cnt;
                    end
                end
            end
            lpca_pkg::ST_DIV_ANG: begin
                if (div_rsp.done) begin
                    mean_a_next = div_rsp.quot[lpca_pkg::MEAN_A_W-1:0];
                    kick_next   = 1'b1;
                end
            end
            lpca_pkg::ST_DIV_DST: begin
                if (div_rsp.done) begin
                    mean_d_next = div_rsp.quot;
                end
            end
            lpca_pkg::ST_SEND: begin
                if (m_ready && pend_end_reg) begin
                    // second result: flush the cluster the breaking point opened
                    job_asum_next   = angle_sum_reg;
                    job_dsum_next   = dist_sum_reg;
                    job_cnt_next    = count_reg;
                    job_done_next   = 1'b1;
                    job_last_next   = 1'b1;
                    pend_end_next   = 1'b0;
                    prev_angle_next = '0;
                    prev_dist_next  = '0;
                    angle_sum_next  = '0;
                    dist_sum_next   = '0;
                    count_next      = '0;
                    kick_next       = count_reg != '0;
                    if (count_reg == '0) begin
                        mean_a_next = '0;
                        mean_d_next = '0;
                    end
                end
            end
            default: begin
                kick_next = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // divider request: sum high bits seed the remainder, low bits shift in
    // ------------------------------------------------------------------
    assign div_sum = (state_reg == lpca_pkg::ST_DIV_ANG) ? job_asum_reg : job_dsum_reg;

    assign div_req.start    = kick_reg;
    assign div_req.steps    = (state_reg == lpca_pkg::ST_DIV_ANG) ? lpca_pkg::STEPS_ANGLE
                                                                  : lpca_pkg::STEPS_DIST;
    assign div_req.divisor  = job_cnt_reg;
    assign div_req.rem_init = lpca_pkg::CNT_W'(div_sum[lpca_pkg::SUM_W-1:lpca_pkg::ANGLE_W]);
    assign div_req.low_bits = {div_sum[lpca_pkg::ANGLE_W-1:0], 2'b00};

    lpca_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ------------------------------------------------------------------
    // channel outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_ready   = state_reg == lpca_pkg::ST_IDLE;
        m_valid   = state_reg == lpca_pkg::ST_SEND;
        cfg_ready = 1'b1;
    end

    assign m_mean_angle   = mean_a_reg;
    assign m_mean_dist_q2 = mean_d_reg;
    assign m_point_count  = job_cnt_reg;
    assign m_scan_done    = job_done_reg;
    assign m_last_of_run  = job_last_reg;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= lpca_pkg::ST_IDLE;
            angle_gap_reg  <= lpca_pkg::ANGLE_GAP_RESET;
            dist_gap_reg   <= lpca_pkg::DIST_GAP_RESET;
            prev_angle_reg <= '0;
            prev_dist_reg  <= '0;
            angle_sum_reg  <= '0;
            dist_sum_reg   <= '0;
            count_reg      <= '0;
            pend_end_reg   <= 1'b0;
            kick_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            prev_angle_reg <= prev_angle_next;
            prev_dist_reg  <= prev_dist_next;
            angle_sum_reg  <= angle_sum_next;
            dist_sum_reg   <= dist_sum_next;
            count_reg      <= count_next;
            pend_end_reg   <= pend_end_next;
            kick_reg       <= kick_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    lpca_pkg::CFG_ANGLE_GAP: angle_gap_reg <= cfg_data;
                    lpca_pkg::CFG_DIST_GAP:  dist_gap_reg  <= cfg_data;
                    default: begin
                        angle_gap_reg <= angle_gap_reg;
                    end
                endcase
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        job_asum_reg <= job_asum_next;
        job_dsum_reg <= job_dsum_next;
        job_cnt_reg  <= job_cnt_next;
        job_done_reg <= job_done_next;
        job_last_reg <= job_last_next;
        mean_a_reg   <= mean_a_next;
        mean_d_reg   <= mean_d_next;
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_pend_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_end_reg |-> (state_reg != lpca_pkg::ST_IDLE))
        else $error("pending flush left behind in idle");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_scan_done) |-> m_last_of_run)
        else $error("scan done result not last of run");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_point_count == '0)) |-> ((m_mean_angle == '0)
            && (m_mean_dist_q2 == '0) && m_scan_done))
        else $error("empty marker carries nonzero fields");

    a_run_goes_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> !s_ready)
        else $error("input taken before last result of run");

endmodule

/* hdl/lpca_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpca_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lpca_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  lpca_pkg::div_req_t req,
    output lpca_pkg::div_rsp_t rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [lpca_pkg::STEP_W-1:0]       cnt_reg, cnt_next;
    logic [lpca_pkg::CNT_W-1:0]        rem_reg, rem_next;
    logic [lpca_pkg::QUOT_W-1:0]       low_reg, low_next;
    logic [lpca_pkg::QUOT_W-1:0]       quot_reg, quot_next;
    logic [lpca_pkg::CNT_W:0]          trial;
    logic [lpca_pkg::CNT_W:0]          diff;
    logic                              ge;

    // trial subtract of the shifted partial remainder
    assign trial = {rem_reg, low_reg[lpca_pkg::QUOT_W-1]};
    assign diff  = trial - {1'b0, req.divisor};
    assign ge    = trial >= {1'b0, req.divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = req.rem_init;
            low_next  = req.low_bits;
            quot_next = '0;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[lpca_pkg::CNT_W-1:0] : trial[lpca_pkg::CNT_W-1:0];
            quot_next = {quot_reg[lpca_pkg::QUOT_W-2:0], ge};
            low_next  = {low_reg[lpca_pkg::QUOT_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == lpca_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("divider done held more than one cycle");

endmodule
